FILE: hw/rtl/xmb_pkg.sv
// ---------------------------------------------------------------------------
// xmb_pkg
// Shared types, constants and helpers of the XOR-metric bucket table.
// ---------------------------------------------------------------------------
package xmb_pkg;

	localparam int ID_BITS     = 64;
	localparam int BUCKET_SIZE = 8;
	localparam int RESULT_CAP  = 8;

	localparam int BKT_W  = $clog2(ID_BITS);
	localparam int SLOT_W = $clog2(BUCKET_SIZE);
	localparam int ADDR_W = BKT_W + SLOT_W;
	localparam int FILL_W = $clog2(BUCKET_SIZE + 1);
	localparam int CNT_W  = $clog2(RESULT_CAP + 1);
	localparam int PFX_W  = 7;
	localparam int AGE_W  = 21;

	localparam logic [1:0] REQ_ADD     = 2'd0;
	localparam logic [1:0] REQ_FIND    = 2'd1;
	localparam logic [1:0] REQ_REFRESH = 2'd2;

	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_REPLACED  = 3'd2;
	localparam logic [2:0] ST_DROPPED   = 3'd3;
	localparam logic [2:0] ST_SELF      = 3'd4;
	localparam logic [2:0] ST_FOUND     = 3'd5;
	localparam logic [2:0] ST_NONE      = 3'd6;
	localparam logic [2:0] ST_REFRESHED = 3'd7;

	localparam logic [1:0] REG_SELF_ID = 2'd0;
	localparam logic [1:0] REG_RINT    = 2'd1;
	localparam logic [1:0] REG_RAGE    = 2'd2;

	typedef struct packed {
		logic [63:0] id;
		logic [31:0] addr;
		logic [15:0] port;
		logic [31:0] seen;
	} peer_t;

	typedef struct packed {
		logic             clear;
		logic             ins;
		logic [CNT_W-1:0] maxc;
	} list_ctl_t;

	typedef enum logic [3:0] {
		FS_IDLE,
		FS_ADD_PREP,
		FS_ADD_SCAN,
		FS_ADD_DRAIN,
		FS_ADD_DEC,
		FS_FIND_SCAN,
		FS_FIND_DRAIN,
		FS_FIND_EMIT,
		FS_REF_SCAN,
		FS_REF_DRAIN,
		FS_RESP
	} fsm_t;

	// count of leading equal bits, x is the xor of the two ids
	function automatic logic [PFX_W-1:0] lead_eq(input logic [ID_BITS-1:0] x);
		logic [PFX_W-1:0] n;
		n = PFX_W'(ID_BITS);
		for (int i = 0; i < ID_BITS; i++) begin
			if (x[i]) n = PFX_W'(ID_BITS - 1 - i);
		end
		return n;
	endfunction

	function automatic logic [31:0] age_of(input logic [31:0] now, input logic [31:0] seen);
		return (now >= seen) ? (now - seen) : 32'd0;
	endfunction

endpackage

FILE: hw/rtl/xmb_req_if.sv
// ---------------------------------------------------------------------------
// xmb_req_if
// Request channel: valid/ready handshake with one request item.
// ---------------------------------------------------------------------------
interface xmb_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [63:0] node_id;
	logic [31:0] node_addr;
	logic [15:0] node_port;
	logic [31:0] now_seconds;
	logic [3:0]  max_count;

	modport source (output valid, req_type, node_id, node_addr, node_port, now_seconds,
		max_count, input ready);
	modport sink (input valid, req_type, node_id, node_addr, node_port, now_seconds,
		max_count, output ready);
endinterface

FILE: hw/rtl/xmb_res_if.sv
// ---------------------------------------------------------------------------
// xmb_res_if
// Result channel: valid/ready handshake with one result item.
// ---------------------------------------------------------------------------
interface xmb_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] res_id;
	logic [31:0] res_addr;
	logic [15:0] res_port;
	logic [6:0]  res_prefix;
	logic        last;

	modport source (output valid, status, res_id, res_addr, res_port, res_prefix, last,
		input ready);
	modport sink (input valid, status, res_id, res_addr, res_port, res_prefix, last,
		output ready);
endinterface

FILE: hw/rtl/xmb_best_list.sv
// ---------------------------------------------------------------------------
// xmb_best_list
// Sorted list of the closest peers seen during a find scan.
// ---------------------------------------------------------------------------
module xmb_best_list (
	input  logic                      clk,
	input  logic                      arst_n,
	input  xmb_pkg::list_ctl_t        ctl,
	input  logic [xmb_pkg::PFX_W-1:0] new_pfx,
	input  xmb_pkg::peer_t            new_peer,
	input  logic [xmb_pkg::CNT_W-1:0] sel,
	output logic [xmb_pkg::CNT_W-1:0] cnt,
	output logic [xmb_pkg::PFX_W-1:0] sel_pfx,
	output xmb_pkg::peer_t            sel_peer
);
	import xmb_pkg::*;

	logic [CNT_W-1:0] cnt_q, cnt_d, pos;
	logic [PFX_W-1:0] pfx_q [RESULT_CAP];
	logic [PFX_W-1:0] pfx_d [RESULT_CAP];
	peer_t            peer_q [RESULT_CAP];
	peer_t            peer_d [RESULT_CAP];

	// equal prefixes keep scan order: new item goes after them
	always_comb begin
		pos = '0;
		for (int i = 0; i < RESULT_CAP; i++) begin
			if ((CNT_W'(i) < cnt_q) && (pfx_q[i] >= new_pfx)) pos = pos + 1'b1;
		end
		cnt_d = cnt_q;
		for (int i = 0; i < RESULT_CAP; i++) begin
			pfx_d[i]  = pfx_q[i];
			peer_d[i] = peer_q[i];
		end
		if (ctl.clear) begin
			cnt_d = '0;
		end else if (ctl.ins && (pos < ctl.maxc)) begin
			if (cnt_q < ctl.maxc) cnt_d = cnt_q + 1'b1;
			for (int i = 0; i < RESULT_CAP; i++) begin
				if (CNT_W'(i) == pos) begin
					pfx_d[i]  = new_pfx;
					peer_d[i] = new_peer;
				end else if ((CNT_W'(i) > pos) && (i > 0)) begin
					pfx_d[i]  = pfx_q[i-1];
					peer_d[i] = peer_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else         cnt_q <= cnt_d;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < RESULT_CAP; i++) begin
			pfx_q[i]  <= pfx_d[i];
			peer_q[i] <= peer_d[i];
		end
	end

	assign cnt      = cnt_q;
	assign sel_pfx  = pfx_q[sel[$clog2(RESULT_CAP)-1:0]];
	assign sel_peer = peer_q[sel[$clog2(RESULT_CAP)-1:0]];

endmodule

FILE: hw/rtl/xor_metric_bucket_table_core.sv
// ---------------------------------------------------------------------------
// xor_metric_bucket_table_core
// Peer routing table over 64 buckets of 8 peers, held in block memory.
// ---------------------------------------------------------------------------
// Usage: requests enter on req, results leave on res (valid/ready each);
// registers sit on the APB port (self_id at 0x00, refresh_interval at 0x08,
// replace_age at 0x10); the user must write them only while no request is
// in progress, the block does not enforce this. One request is in progress
// at a time; req.ready is high when idle, even while a result waits in the
// output register. Add: unless the id is self_id, reads the 8 slots of its
// bucket through the peer memory port, then gives one result. Find: scans
// all 512 peer entries, one per cycle through the single read port, then
// emits its sorted list, one result per cycle while the receiver takes them.
// Refresh: the same scan of all 512 entries, compacting each bucket through
// the write port, then one result. Other request codes give a single "none"
// result. Reset clears bucket fill valid bits at once, so the table starts
// empty with no clearing pass; registers take 0, 900 and 3600.
// A stalled receiver holds the result in the output register and the
// request sequence waits until it is taken.
// ---------------------------------------------------------------------------
module xor_metric_bucket_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	xmb_req_if.sink     req,
	xmb_res_if.source   res
);
	import xmb_pkg::*;

	// registers
	logic [63:0]      self_id_q;
	logic [AGE_W-1:0] rint_q, rage_q;
	logic             cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_id_q <= '0;
			rint_q    <= AGE_W'(900);
			rage_q    <= AGE_W'(3600);
		end else if (cfg_we) begin
			unique case (paddr[4:3])
				REG_SELF_ID: self_id_q <= pwdata;
				REG_RINT:    rint_q    <= pwdata[AGE_W-1:0];
				REG_RAGE:    rage_q    <= pwdata[AGE_W-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_SELF_ID: prdata = self_id_q;
			REG_RINT:    prdata = {{(64-AGE_W){1'b0}}, rint_q};
			REG_RAGE:    prdata = {{(64-AGE_W){1'b0}}, rage_q};
			default:     prdata = '0;
		endcase
	end

	// request capture
	fsm_t              state_q, state_d;
	logic              req_acc;
	logic [63:0]       id_q;
	logic [31:0]       addr_q, now_q;
	logic [15:0]       port_q;
	logic [CNT_W-1:0]  maxc_q;
	logic [ADDR_W-1:0] scan_q;

	assign req.ready = (state_q == FS_IDLE);
	assign req_acc   = req.valid & req.ready;

	always_ff @(posedge clk) begin
		if (req_acc) begin
			id_q   <= req.node_id;
			addr_q <= req.node_addr;
			port_q <= req.node_port;
			now_q  <= req.now_seconds;
			maxc_q <= (req.max_count > 4'(RESULT_CAP)) ? CNT_W'(RESULT_CAP)
				: CNT_W'(req.max_count);
		end
	end

	// memories
	peer_t             peer_mem [ID_BITS*BUCKET_SIZE];
	logic [FILL_W-1:0] fill_mem [ID_BITS];
	logic [ID_BITS-1:0] fill_vld_q;

	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              peer_we;
	logic [ADDR_W-1:0] peer_waddr;
	peer_t             peer_wd;
	logic              fill_we;
	logic [BKT_W-1:0]  fill_waddr;
	logic [FILL_W-1:0] fill_wd;

	peer_t             peer_s1;
	logic [FILL_W-1:0] fill_raw_s1, fill_s1;
	logic              fvld_s1, v_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [BKT_W-1:0]  bkt_s1;
	logic              ok_s1;

	always_ff @(posedge clk) begin
		if (peer_we) peer_mem[peer_waddr] <= peer_wd;
		if (fill_we) fill_mem[fill_waddr] <= fill_wd;
		if (rd_en) begin
			peer_s1     <= peer_mem[rd_addr];
			fill_raw_s1 <= fill_mem[rd_addr[ADDR_W-1:SLOT_W]];
			fvld_s1     <= fill_vld_q[rd_addr[ADDR_W-1:SLOT_W]];
			slot_s1     <= rd_addr[SLOT_W-1:0];
			bkt_s1      <= rd_addr[ADDR_W-1:SLOT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_vld_q <= '0;
			v_s1       <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			if (fill_we) fill_vld_q[fill_waddr] <= 1'b1;
		end
	end

	assign fill_s1 = fvld_s1 ? fill_raw_s1 : '0;
	assign ok_s1   = v_s1 && (FILL_W'(slot_s1) < fill_s1);

	// add bookkeeping
	logic [PFX_W-1:0]  add_b_q, self_pfx;
	logic              match_q;
	logic [SLOT_W-1:0] match_slot_q, old_slot_q;
	logic [31:0]       old_seen_q;
	logic [FILL_W-1:0] add_fill_q;
	logic              add_mode, ref_mode, find_mode;
	logic              add_we, add_fill_we;
	logic [SLOT_W-1:0] add_slot;
	logic [2:0]        add_status;

	assign self_pfx  = lead_eq(self_id_q ^ id_q);
	assign add_mode  = (state_q == FS_ADD_SCAN) || (state_q == FS_ADD_DRAIN);
	assign ref_mode  = (state_q == FS_REF_SCAN) || (state_q == FS_REF_DRAIN);
	assign find_mode = (state_q == FS_FIND_SCAN) || (state_q == FS_FIND_DRAIN);

	always_ff @(posedge clk) begin
		if (state_q == FS_ADD_PREP) add_b_q <= self_pfx;
		if (req_acc) match_q <= 1'b0;
		if (add_mode && v_s1) begin
			add_fill_q <= fill_s1;
			if (ok_s1 && (peer_s1.id == id_q)) begin
				match_q      <= 1'b1;
				match_slot_q <= slot_s1;
			end
			if (ok_s1 && ((slot_s1 == '0) || (peer_s1.seen < old_seen_q))) begin
				old_seen_q <= peer_s1.seen;
				old_slot_q <= slot_s1;
			end
		end
	end

	always_comb begin
		add_we      = 1'b0;
		add_fill_we = 1'b0;
		add_slot    = old_slot_q;
		add_status  = ST_DROPPED;
		if (match_q) begin
			add_we     = 1'b1;
			add_slot   = match_slot_q;
			add_status = ST_UPDATED;
		end else if (add_fill_q < FILL_W'(BUCKET_SIZE)) begin
			add_we      = 1'b1;
			add_fill_we = 1'b1;
			add_slot    = add_fill_q[SLOT_W-1:0];
			add_status  = ST_ADDED;
		end else if (age_of(now_q, old_seen_q) > {{(32-AGE_W){1'b0}}, rage_q}) begin
			add_we     = 1'b1;
			add_status = ST_REPLACED;
		end
	end

	// refresh compaction
	logic [FILL_W-1:0] ref_w_q, ref_w_cur, ref_w_nxt;
	logic              ref_keep;

	assign ref_w_cur = (slot_s1 == '0) ? '0 : ref_w_q;
	assign ref_keep  = ok_s1 &&
		!(age_of(now_q, peer_s1.seen) > {{(32-AGE_W-1){1'b0}}, rint_q, 1'b0});
	assign ref_w_nxt = ref_w_cur + FILL_W'(ref_keep);

	always_ff @(posedge clk) begin
		if (ref_mode && v_s1) ref_w_q <= ref_w_nxt;
	end

	// write port arbitration
	always_comb begin
		peer_we    = 1'b0;
		peer_waddr = {bkt_s1, ref_w_cur[SLOT_W-1:0]};
		peer_wd    = peer_s1;
		fill_we    = 1'b0;
		fill_waddr = bkt_s1;
		fill_wd    = ref_w_nxt;
		if (state_q == FS_ADD_DEC) begin
			peer_we    = add_we;
			peer_waddr = {add_b_q[BKT_W-1:0], add_slot};
			peer_wd    = '{id: id_q, addr: addr_q, port: port_q, seen: now_q};
			fill_we    = add_fill_we;
			fill_waddr = add_b_q[BKT_W-1:0];
			fill_wd    = add_fill_q + 1'b1;
		end else if (ref_mode && v_s1) begin
			peer_we = ref_keep;
			fill_we = (slot_s1 == '1);
		end
	end

	// find path
	logic             v_s2, ok_s2;
	logic [PFX_W-1:0] pfx_s2;
	peer_t            peer_s2;
	list_ctl_t        lst_ctl;
	logic [CNT_W-1:0] lst_cnt, emit_q;
	logic [PFX_W-1:0] lst_pfx;
	peer_t            lst_peer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1 && find_mode;
	end

	always_ff @(posedge clk) begin
		ok_s2   <= ok_s1;
		pfx_s2  <= lead_eq(id_q ^ peer_s1.id);
		peer_s2 <= peer_s1;
	end

	assign lst_ctl = '{clear: req_acc, ins: v_s2 && ok_s2, maxc: maxc_q};

	xmb_best_list u_list (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (lst_ctl),
		.new_pfx  (pfx_s2),
		.new_peer (peer_s2),
		.sel      (emit_q),
		.cnt      (lst_cnt),
		.sel_pfx  (lst_pfx),
		.sel_peer (lst_peer)
	);

	// single-result register
	logic [2:0]       resp_status_q;
	logic [63:0]      resp_id_q;
	logic [31:0]      resp_addr_q;
	logic [15:0]      resp_port_q;
	logic [PFX_W-1:0] resp_pfx_q;

	always_ff @(posedge clk) begin
		if (req_acc) begin
			resp_status_q <= ST_NONE;
			resp_id_q     <= '0;
			resp_addr_q   <= '0;
			resp_port_q   <= '0;
			resp_pfx_q    <= '0;
		end else if (state_q == FS_ADD_PREP) begin
			resp_status_q <= ST_SELF;
			resp_id_q     <= id_q;
			resp_addr_q   <= addr_q;
			resp_port_q   <= port_q;
			resp_pfx_q    <= PFX_W'(ID_BITS);
		end else if (state_q == FS_ADD_DEC) begin
			resp_status_q <= add_status;
			resp_pfx_q    <= add_b_q;
		end else if (state_q == FS_REF_DRAIN) begin
			resp_status_q <= ST_REFRESHED;
		end
	end

	// sequencer
	logic             out_free, out_load, out_last, emit_inc;
	logic [2:0]       out_status;
	peer_t            out_peer;
	logic [PFX_W-1:0] out_pfx;

	assign out_free = !res.valid || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FS_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		rd_addr    = scan_q;
		out_load   = 1'b0;
		emit_inc   = 1'b0;
		out_status = resp_status_q;
		out_peer   = '{id: resp_id_q, addr: resp_addr_q, port: resp_port_q, seen: '0};
		out_pfx    = resp_pfx_q;
		out_last   = 1'b1;
		unique case (state_q)
			FS_IDLE: begin
				if (req_acc) begin
					unique case (req.req_type)
						REQ_ADD:     state_d = FS_ADD_PREP;
						REQ_FIND:    state_d = FS_FIND_SCAN;
						REQ_REFRESH: state_d = FS_REF_SCAN;
						default:     state_d = FS_RESP;
					endcase
				end
			end
			FS_ADD_PREP: begin
				state_d = (self_pfx == PFX_W'(ID_BITS)) ? FS_RESP : FS_ADD_SCAN;
			end
			FS_ADD_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = {add_b_q[BKT_W-1:0], scan_q[SLOT_W-1:0]};
				if (scan_q[SLOT_W-1:0] == '1) state_d = FS_ADD_DRAIN;
			end
			FS_ADD_DRAIN: begin
				if (!v_s1) state_d = FS_ADD_DEC;
			end
			FS_ADD_DEC: state_d = FS_RESP;
			FS_FIND_SCAN: begin
				rd_en = 1'b1;
				if (scan_q == '1) state_d = FS_FIND_DRAIN;
			end
			FS_FIND_DRAIN: begin
				if (!v_s1 && !v_s2) state_d = FS_FIND_EMIT;
			end
			FS_FIND_EMIT: begin
				if (lst_cnt != '0) begin
					out_status = ST_FOUND;
					out_peer   = lst_peer;
					out_pfx    = lst_pfx;
					out_last   = (emit_q == lst_cnt - 1'b1);
				end else begin
					out_status = ST_NONE;
					out_peer   = '0;
					out_pfx    = '0;
				end
				if (out_free) begin
					out_load = 1'b1;
					if (out_last) state_d = FS_IDLE;
					else          emit_inc = 1'b1;
				end
			end
			FS_REF_SCAN: begin
				rd_en = 1'b1;
				if (scan_q == '1) state_d = FS_REF_DRAIN;
			end
			FS_REF_DRAIN: begin
				if (!v_s1) state_d = FS_RESP;
			end
			FS_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = FS_IDLE;
				end
			end
			default: state_d = FS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			emit_q <= '0;
		end else begin
			if (req_acc)    scan_q <= '0;
			else if (rd_en) scan_q <= scan_q + 1'b1;
			if (req_acc)       emit_q <= '0;
			else if (emit_inc) emit_q <= emit_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        res.valid <= 1'b0;
		else if (out_load)  res.valid <= 1'b1;
		else if (res.ready) res.valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res.status     <= out_status;
			res.res_id     <= out_peer.id;
			res.res_addr   <= out_peer.addr;
			res.res_port   <= out_peer.port;
			res.res_prefix <= out_pfx;
			res.last       <= out_last;
		end
	end

	a_list_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lst_cnt <= maxc_q || state_q == FS_IDLE)
		else $error("find list exceeds requested count");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_we |-> fill_wd <= FILL_W'(BUCKET_SIZE))
		else $error("bucket fill beyond capacity");

	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FS_FIND_EMIT |-> !v_s1 && !v_s2)
		else $error("emitting before scan pipeline drained");

	a_no_load_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result overwritten while held");

	a_s2_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("find stage without read");

endmodule

FILE: test/xor_metric_bucket_table_core_test.sv
// ---------------------------------------------------------------------------
// xor_metric_bucket_table_core_test
// Checks the bucket table against its own prediction of the routing state.
// Requests go through the handshake with random gaps. The result side
// stalls at random. Each result is checked field by field, in order.
// Three register settings are used in turn, self_id 0 and all ones among them.
// ---------------------------------------------------------------------------
module xor_metric_bucket_table_core_test;
	import xmb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0]  kind;
		logic [63:0] id;
		logic [31:0] addr;
		logic [15:0] port;
		logic [31:0] now;
		logic [3:0]  maxc;
	} request_t;

	typedef struct {
		logic [2:0]  status;
		logic [63:0] id;
		logic [31:0] addr;
		logic [15:0] port;
		logic [6:0]  prefix;
		logic        last;
	} answer_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [63:0] pwdata, prdata;
	logic pready;

	xmb_req_if req ();
	xmb_res_if res ();

	xor_metric_bucket_table_core DUT (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req.sink), .res(res.source)
	);

	// predicted table and registers
	peer_t       table_peer [ID_BITS][BUCKET_SIZE];
	int          table_fill [ID_BITS];
	logic [63:0] cfg_self;
	logic [20:0] cfg_rint, cfg_rage;

	request_t pending_req [$];
	answer_t  expected_ans [$];
	logic [63:0] known_ids [$];
	int  mismatches;
	bit  calm;
	int  tx_gap, rx_gap;
	logic [31:0] clock_s;

	function automatic int prefix_len(logic [63:0] a, logic [63:0] b);
		logic [63:0] x;
		int n;
		x = a ^ b;
		n = 0;
		for (int i = 63; i >= 0; i--) begin
			if (x[i]) break;
			n++;
		end
		return n;
	endfunction

	function automatic logic [32:0] age(logic [31:0] now, logic [31:0] seen);
		return (now >= seen) ? {1'b0, now - seen} : 33'd0;
	endfunction

	function automatic answer_t ans(logic [2:0] st, logic [63:0] id, logic [31:0] a,
			logic [15:0] p, int pfx);
		answer_t r;
		r.status = st; r.id = id; r.addr = a; r.port = p; r.prefix = 7'(pfx); r.last = 1'b1;
		return r;
	endfunction

	task automatic predict_table(request_t q);
		int b, f, old, n, lim;
		logic [33:0] evict;
		answer_t r;
		peer_t np;
		case (q.kind)
			REQ_ADD: begin
				b = prefix_len(cfg_self, q.id);
				np.id = q.id; np.addr = q.addr; np.port = q.port; np.seen = q.now;
				if (b >= ID_BITS) begin
					expected_ans.push_back(ans(ST_SELF, q.id, q.addr, q.port, ID_BITS));
					return;
				end
				f = table_fill[b];
				for (int i = 0; i < f; i++) begin
					if (table_peer[b][i].id == q.id) begin
						table_peer[b][i] = np;
						expected_ans.push_back(ans(ST_UPDATED, q.id, q.addr, q.port, b));
						return;
					end
				end
				if (f < BUCKET_SIZE) begin
					table_peer[b][f] = np;
					table_fill[b] = f + 1;
					expected_ans.push_back(ans(ST_ADDED, q.id, q.addr, q.port, b));
					return;
				end
				old = 0;
				for (int i = 1; i < f; i++)
					if (table_peer[b][i].seen < table_peer[b][old].seen) old = i;
				if (age(q.now, table_peer[b][old].seen) > {12'd0, cfg_rage}) begin
					table_peer[b][old] = np;
					expected_ans.push_back(ans(ST_REPLACED, q.id, q.addr, q.port, b));
				end else begin
					expected_ans.push_back(ans(ST_DROPPED, q.id, q.addr, q.port, b));
				end
			end
			REQ_FIND: begin
				lim = (q.maxc > RESULT_CAP) ? RESULT_CAP : q.maxc;
				n = 0;
				for (int p = ID_BITS; p >= 0 && n < lim; p--)
					for (int bb = 0; bb < ID_BITS && n < lim; bb++)
						for (int s = 0; s < table_fill[bb] && n < lim; s++)
							if (prefix_len(q.id, table_peer[bb][s].id) == p) begin
								r = ans(ST_FOUND, table_peer[bb][s].id,
									table_peer[bb][s].addr, table_peer[bb][s].port, p);
								r.last = 1'b0;
								expected_ans.push_back(r);
								n++;
							end
				if (n == 0) expected_ans.push_back(ans(ST_NONE, 0, 0, 0, 0));
				else expected_ans[$].last = 1'b1;
			end
			REQ_REFRESH: begin
				evict = {13'd0, cfg_rint} * 2;
				for (int bb = 0; bb < ID_BITS; bb++) begin
					n = 0;
					for (int s = 0; s < table_fill[bb]; s++)
						if (!({1'b0, age(q.now, table_peer[bb][s].seen)} > evict)) begin
							table_peer[bb][n] = table_peer[bb][s];
							n++;
						end
					table_fill[bb] = n;
				end
				expected_ans.push_back(ans(ST_REFRESHED, 0, 0, 0, 0));
			end
			default: expected_ans.push_back(ans(ST_NONE, 0, 0, 0, 0));
		endcase
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (req.valid && req.ready) begin
				predict_table(pending_req[0]);
				void'(pending_req.pop_front());
			end
			if (!(req.valid && !req.ready)) begin
				if (tx_gap > 0) begin
					tx_gap--;
					req.valid <= 1'b0;
				end else if (pending_req.size() > 0) begin
					if (!calm && $urandom_range(0, 5) == 0) begin
						tx_gap = $urandom_range(1, 7) - 1;
						req.valid <= 1'b0;
					end else begin
						req.valid       <= 1'b1;
						req.req_type    <= pending_req[0].kind;
						req.node_id     <= pending_req[0].id;
						req.node_addr   <= pending_req[0].addr;
						req.node_port   <= pending_req[0].port;
						req.now_seconds <= pending_req[0].now;
						req.max_count   <= pending_req[0].maxc;
					end
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			rx_gap = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_ans.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result status %0d", res.status);
				end else begin
					answer_t e;
					e = expected_ans.pop_front();
					if (res.status !== e.status || res.res_id !== e.id || res.res_addr !== e.addr
							|| res.res_port !== e.port || res.res_prefix !== e.prefix
							|| res.last !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp st%0d %h %h %h p%0d l%0d got st%0d %h %h %h p%0d l%0d",
								e.status, e.id, e.addr, e.port, e.prefix, e.last, res.status,
								res.res_id, res.res_addr, res.res_port, res.res_prefix, res.last);
					end
				end
			end
			if (rx_gap > 0) begin
				rx_gap--;
				res.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rx_gap = $urandom_range(1, 7) - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] id_in_bucket(int b);
		logic [63:0] lower;
		lower = (b >= 63) ? 64'd0 : (~64'd0 >> (b + 1));
		return cfg_self ^ (64'h8000_0000_0000_0000 >> b) ^ (rand64() & lower);
	endfunction

	task automatic queue_req(logic [1:0] k, logic [63:0] id, logic [3:0] mc);
		request_t q;
		clock_s = clock_s + (($urandom_range(0, 19) == 0) ? $urandom_range(500, 5000)
			: $urandom_range(0, 40));
		q.kind = k; q.id = id; q.addr = $urandom; q.port = 16'($urandom);
		q.now = clock_s; q.maxc = mc;
		if (k == REQ_ADD) known_ids.push_back(id);
		pending_req.push_back(q);
	endtask

	task automatic queue_random(int count);
		int r;
		int hot [5] = '{0, 1, 2, 3, 63};
		logic [63:0] id;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 58) begin
				if (r < 12 && known_ids.size() > 0)
					id = known_ids[$urandom_range(0, known_ids.size() - 1)];
				else if (r < 14) id = cfg_self;
				else if (r < 50) id = id_in_bucket(hot[$urandom_range(0, 4)]);
				else id = rand64();
				queue_req(REQ_ADD, id, 4'($urandom));
			end else if (r < 85) begin
				id = (r < 70 && known_ids.size() > 0) ?
					known_ids[$urandom_range(0, known_ids.size() - 1)] : rand64();
				queue_req(REQ_FIND, id, 4'($urandom_range(0, 15)));
			end else if (r < 95) begin
				queue_req(REQ_REFRESH, rand64(), 4'($urandom));
			end else begin
				queue_req(2'd3, rand64(), 4'($urandom));
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_req.size() > 0 || req.valid || expected_ans.size() > 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [63:0] v);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 3'b000}; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_SELF_ID: cfg_self = v;
			REG_RINT:    cfg_rint = v[20:0];
			REG_RAGE:    cfg_rage = v[20:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [63:0] s, logic [63:0] ri, logic [63:0] ra);
		wait_idle();
		write_reg(REG_SELF_ID, s);
		write_reg(REG_RINT, ri);
		write_reg(REG_RAGE, ra);
		known_ids.delete();
	endtask

	initial begin
		mismatches = 0;
		calm = 1'b0;
		clock_s = 0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		req.valid = 1'b0; req.req_type = '0; req.node_id = '0; req.node_addr = '0;
		req.node_port = '0; req.now_seconds = '0; req.max_count = '0;
		res.ready = 1'b0;
		cfg_self = '0; cfg_rint = 21'd900; cfg_rage = 21'd3600;
		foreach (table_fill[b]) table_fill[b] = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, self add, edges, full bucket, unknown code
		queue_req(REQ_FIND, 64'd0, 4'd8);
		queue_req(REQ_ADD, 64'd0, 4'd0);
		queue_req(REQ_ADD, ~64'd0, 4'd0);
		queue_req(REQ_ADD, 64'd1, 4'd0);
		queue_req(REQ_ADD, 64'd1, 4'd0);
		for (int i = 0; i < 9; i++) queue_req(REQ_ADD, id_in_bucket(1), 4'd0);
		clock_s = clock_s + 4000;
		queue_req(REQ_ADD, id_in_bucket(1), 4'd0);
		queue_req(REQ_FIND, ~64'd0, 4'd0);
		queue_req(REQ_FIND, ~64'd0, 4'd15);
		queue_req(REQ_FIND, 64'd1, 4'd3);
		queue_req(2'd3, ~64'd0, 4'hF);
		queue_req(REQ_REFRESH, 64'd0, 4'd0);
		queue_random(80);

		set_regs(64'd0, 64'd1, 64'd0);
		queue_random(95);

		set_regs(~64'd0, 64'd1048576, 64'd1048576);
		clock_s = 32'hFF00_0000;
		queue_random(40);
		wait_idle();
		calm = 1'b1;
		queue_random(60);
		wait_idle();

		if (mismatches == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule

FILE: filelist.f
hw/rtl/xmb_pkg.sv
hw/rtl/xmb_req_if.sv
hw/rtl/xmb_res_if.sv
hw/rtl/xmb_best_list.sv
hw/rtl/xor_metric_bucket_table_core.sv
test/xor_metric_bucket_table_core_test.sv
